// File: rtl/core/cycling_rev_event_synthesizer_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cycling revolution event synthesizer
// ----------------------------------------------------------------------------
`ifndef CYCLING_REV_EVENT_SYNTHESIZER_TOP_DEFINES_SVH
`define CYCLING_REV_EVENT_SYNTHESIZER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CRES_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cres assertion failed");

// Next-cycle implication, disabled during reset.
`define CRES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cres assertion failed");

`endif

// File: rtl/core/cres_pkg.sv
// ----------------------------------------------------------------------------
// cres_pkg
// Shared widths, constants, state types and the lane command struct.
// ----------------------------------------------------------------------------
`default_nettype none

package cres_pkg;

  // Field widths
  localparam int SPEED_W    = 8;
  localparam int CAD_W      = 8;
  localparam int MS_W       = 16;
  localparam int PWR_W      = 16;
  localparam int CIRC_W     = 12;
  localparam int FLAGS_W    = 8;
  localparam int WREV_W     = 32;
  localparam int TIME_W     = 16;
  localparam int CREV_W     = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 12;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CIRC = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 8'd1;

  localparam logic [CIRC_W-1:0]  CIRC_RESET = 12'd2096;
  localparam logic [FLAGS_W-1:0] FLAGS_SC   = 8'h03;
  localparam logic [FLAGS_W-1:0] FLAGS_PWR  = 8'h30;

  // Wheel arithmetic
  localparam int WHEEL_MOD_FACTOR = 18;
  localparam int WHEEL_TIME_DEN   = 2500;
  localparam int SCALE_SC_SH      = 10;   // 1024 ticks per second
  localparam int SCALE_PWR_SH     = 11;   // 2048 ticks per second
  localparam int WFRAC_W  = 17;           // remainder below circ*18
  localparam int WPROD1_W = SPEED_W + MS_W;
  localparam int WTOT_W   = 27;           // remainder + speed*ms*5
  localparam int WDELTA_W = 23;           // total / 18 at most
  // delta*circ never exceeds total/18, so nine times it stays in 26 bits
  localparam int WNINE_W  = 26;
  localparam int WNUM_W   = WNINE_W + SCALE_PWR_SH;
  localparam int WDEN_W   = 20;           // 2500*speed

  localparam int WM_AW = WDELTA_W;
  localparam int WM_BW = CIRC_W;
  localparam int WM_LW = $clog2(WM_BW + 1);
  localparam int WD_NW = WNUM_W;
  localparam int WD_DW = WDEN_W;
  localparam int WD_LW = $clog2(WD_NW + 1);

  // Crank arithmetic
  localparam int CRANK_MOD  = 60000;
  localparam int CTICK_HI_SH = 16;        // 61440 = 2^16 - 2^12
  localparam int CTICK_LO_SH = 12;
  localparam int CFRAC_W  = 16;
  localparam int CPROD_W  = CAD_W + MS_W;
  localparam int CTOT_W   = 25;
  localparam int CDELTA_W = 9;
  localparam int CNUM_W   = CDELTA_W + CTICK_HI_SH;

  localparam int CM_AW = MS_W;
  localparam int CM_BW = CAD_W;
  localparam int CM_LW = $clog2(CM_BW + 1);
  localparam int CD_NW = CTOT_W;
  localparam int CD_DW = CFRAC_W;
  localparam int CD_LW = $clog2(CD_NW + 1);

  typedef enum logic {T_IDLE, T_RUN} top_state_t;

  typedef enum logic [2:0] {W_IDLE, W_MUL1, W_DIV1, W_MUL2, W_DIV2} wheel_state_t;

  typedef enum logic [1:0] {C_IDLE, C_MUL, C_DIV1, C_DIV2} crank_state_t;

  typedef struct packed {
    logic               start;
    logic [SPEED_W-1:0] speed;
    logic [CAD_W-1:0]   cadence;
    logic [MS_W-1:0]    ms;
    logic [CIRC_W-1:0]  circ;
    logic               mode;
  } cres_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/cycling_rev_event_synthesizer_top.sv
// ----------------------------------------------------------------------------
// cycling_rev_event_synthesizer_top
// Builds one speed/cadence (or power) measurement record per input sample.
//
// Input channel (in_valid/in_ready): speed, cadence, elapsed ms and power.
// Output channel (out_valid/out_ready): one record per sample: flags, power,
// cumulative wheel and crank revolutions and their last event times.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 sets the wheel
// circumference in mm, index 1 the report mode; other indexes are dropped.
// One sample is in flight at a time. The wheel and crank lanes run in
// parallel on bit-serial multipliers and dividers; when a wheel revolution
// completes, the wheel lane sets the pace with its multiply, divide, second
// multiply and second divide; otherwise the crank lane can set it.
// The result sits in an output register, so the next sample is taken while
// a stalled record waits; a sample finishing behind a stalled record holds
// until that record transfers.
// Reset clears all counts, remainders and event times, sets the
// circumference to 2096 mm and selects speed-cadence mode.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cycling_rev_event_synthesizer_top_defines.svh"

module cycling_rev_event_synthesizer_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [cres_pkg::SPEED_W-1:0]    in_speed_kmh,
  input  logic [cres_pkg::CAD_W-1:0]      in_cadence_rpm,
  input  logic [cres_pkg::MS_W-1:0]       in_elapsed_ms,
  input  logic [cres_pkg::PWR_W-1:0]      in_power_watts,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [cres_pkg::FLAGS_W-1:0]    out_flags,
  output logic [cres_pkg::PWR_W-1:0]      out_power_out,
  output logic [cres_pkg::WREV_W-1:0]     out_wheel_revs,
  output logic [cres_pkg::TIME_W-1:0]     out_wheel_event_time,
  output logic [cres_pkg::CREV_W-1:0]     out_crank_revs,
  output logic [cres_pkg::TIME_W-1:0]     out_crank_event_time,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cres_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cres_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cres_pkg::*;

  top_state_t state_r, state_nxt;

  logic [CIRC_W-1:0]  circ_r;
  logic               mode_r;
  logic               item_mode_r;
  logic [PWR_W-1:0]   power_r;

  logic               out_valid_r;
  logic [FLAGS_W-1:0] flags_r;
  logic [PWR_W-1:0]   power_out_r;
  logic [WREV_W-1:0]  wheel_revs_r;
  logic [TIME_W-1:0]  wheel_time_r;
  logic [CREV_W-1:0]  crank_revs_r;
  logic [TIME_W-1:0]  crank_time_r;

  cres_cmd_t          cmd;
  logic               accept;
  logic               load_out;
  logic               wheel_busy;
  logic               crank_busy;
  logic [WREV_W-1:0]  wheel_revs;
  logic [TIME_W-1:0]  wheel_time;
  logic [CREV_W-1:0]  crank_revs;
  logic [TIME_W-1:0]  crank_time;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      circ_r <= CIRC_RESET;
      mode_r <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_CIRC) circ_r <= cfg_data[CIRC_W-1:0];
      if (cfg_index == REG_MODE) mode_r <= cfg_data[0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      T_IDLE: if (accept) state_nxt = T_RUN;
      T_RUN:  if (load_out) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    case (state_r)
      T_IDLE: begin
        in_ready = 1'b1;
      end
      T_RUN: begin
        // advance once both lanes finish and the output slot is free
        load_out = !wheel_busy && !crank_busy && (!out_valid_r || out_ready);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    cmd.start   = accept;
    cmd.speed   = in_speed_kmh;
    cmd.cadence = in_cadence_rpm;
    cmd.ms      = in_elapsed_ms;
    cmd.circ    = circ_r;
    cmd.mode    = mode_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_mode_r <= mode_r;
      power_r     <= in_power_watts;
    end
    if (load_out) begin
      flags_r      <= item_mode_r ? FLAGS_PWR : FLAGS_SC;
      power_out_r  <= item_mode_r ? power_r : '0;
      wheel_revs_r <= wheel_revs;
      wheel_time_r <= wheel_time;
      crank_revs_r <= crank_revs;
      crank_time_r <= crank_time;
    end
  end

  cres_wheel u_wheel (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .busy       (wheel_busy),
    .revs       (wheel_revs),
    .event_time (wheel_time)
  );

  cres_crank u_crank (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .busy       (crank_busy),
    .revs       (crank_revs),
    .event_time (crank_time)
  );

  assign out_valid            = out_valid_r;
  assign out_flags            = flags_r;
  assign out_power_out        = power_out_r;
  assign out_wheel_revs       = wheel_revs_r;
  assign out_wheel_event_time = wheel_time_r;
  assign out_crank_revs       = crank_revs_r;
  assign out_crank_event_time = crank_time_r;

  `CRES_ASSERT_HOLDS(a_ready_lanes_idle, clk, rst_n, in_ready, !wheel_busy && !crank_busy)
  `CRES_ASSERT_NEXT(a_transfer_starts_lanes, clk, rst_n, accept, !in_ready && crank_busy)
  `CRES_ASSERT_NEXT(a_load_shows_record, clk, rst_n, load_out, out_valid_r && in_ready)
  `CRES_ASSERT_HOLDS(a_sc_has_no_power, clk, rst_n, out_valid_r && out_flags == FLAGS_SC, out_power_out == '0)

endmodule

`default_nettype wire

// File: rtl/core/cres_smul.sv
// ----------------------------------------------------------------------------
// cres_smul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cres_smul #(
  parameter int AW = cres_pkg::WM_AW,
  parameter int BW = cres_pkg::WM_BW,
  parameter int LW = $clog2(BW + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [AW-1:0]  a,
  input  logic [BW-1:0]  b,
  input  logic [LW-1:0]  len,
  output logic           done,
  output logic [AW+BW-1:0] prod
);
  import cres_pkg::*;

  localparam int PW = AW + BW;

  logic          busy_r;
  logic          done_r;
  logic [LW-1:0] cnt_r;
  logic [PW-1:0] acc_r;
  logic [PW-1:0] mcand_r;
  logic [BW-1:0] mplier_r;
  logic          last;

  assign last = busy_r && (cnt_r == LW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= last;
      if (start) begin
        busy_r <= 1'b1;
      end else if (last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r    <= '0;
      mcand_r  <= PW'(a);
      mplier_r <= b;
      cnt_r    <= len;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
      cnt_r    <= cnt_r - LW'(1);
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

`default_nettype wire

// File: rtl/core/cres_sdiv.sv
// ----------------------------------------------------------------------------
// cres_sdiv
// Restoring divider, one quotient bit per cycle, dividend MSB-aligned.
// ----------------------------------------------------------------------------
`default_nettype none

module cres_sdiv #(
  parameter int NW = cres_pkg::WD_NW,
  parameter int DW = cres_pkg::WD_DW,
  parameter int LW = $clog2(NW + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  input  logic [LW-1:0] len,
  output logic          done,
  output logic [NW-1:0] quotient,
  output logic [DW-1:0] remainder
);
  import cres_pkg::*;

  logic          busy_r;
  logic          done_r;
  logic [LW-1:0] cnt_r;
  logic [DW-1:0] rem_r;
  logic [NW-1:0] dq_r;
  logic [DW-1:0] dvs_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;
  logic [DW-1:0] rem_step;
  logic          last;

  assign trial    = {rem_r, dq_r[NW-1]};
  assign diff     = trial - {1'b0, dvs_r};
  assign fits     = (trial >= {1'b0, dvs_r});
  assign rem_step = fits ? diff[DW-1:0] : trial[DW-1:0];
  assign last     = busy_r && (cnt_r == LW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= last;
      if (start) begin
        busy_r <= 1'b1;
      end else if (last) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Quotient bits shift in from the bottom as dividend bits leave the top.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dq_r  <= dividend;
      dvs_r <= divisor;
      cnt_r <= len;
    end else if (busy_r) begin
      rem_r <= rem_step;
      dq_r  <= {dq_r[NW-2:0], fits};
      cnt_r <= cnt_r - LW'(1);
    end
  end

  assign done      = done_r;
  assign quotient  = dq_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// File: rtl/core/cres_wheel.sv
// ----------------------------------------------------------------------------
// cres_wheel
// Wheel lane: serial distance integration, revolution count, event time.
// ----------------------------------------------------------------------------
`default_nettype none

module cres_wheel (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cres_pkg::cres_cmd_t         cmd,
  output logic                        busy,
  output logic [cres_pkg::WREV_W-1:0] revs,
  output logic [cres_pkg::TIME_W-1:0] event_time
);
  import cres_pkg::*;

  wheel_state_t state_r, state_nxt;

  logic [SPEED_W-1:0] speed_r;
  logic [CIRC_W-1:0]  circ_r;
  logic               mode_r;
  logic [WFRAC_W-1:0] frac_r;
  logic [WREV_W-1:0]  count_r;
  logic [TIME_W-1:0]  time_r;

  logic               mul_start;
  logic [WM_AW-1:0]   mul_a;
  logic [WM_BW-1:0]   mul_b;
  logic [WM_LW-1:0]   mul_len;
  logic               mul_done;
  logic [WM_AW+WM_BW-1:0] mul_prod;

  logic               div_start;
  logic [WD_NW-1:0]   div_dividend;
  logic [WD_DW-1:0]   div_divisor;
  logic [WD_LW-1:0]   div_len;
  logic               div_done;
  logic [WD_NW-1:0]   div_q;
  logic [WD_DW-1:0]   div_rem;

  logic               begin_item;
  logic [WFRAC_W-1:0] modulus;
  logic [WPROD1_W-1:0] prod1;
  logic [WTOT_W-1:0]  total;
  logic [WDELTA_W-1:0] delta;
  logic               advance;
  logic [WDELTA_W-1:0] prod2;
  logic [WNINE_W-1:0] nine;
  logic [WNUM_W-1:0]  num;
  logic [WDEN_W-1:0]  den;
  logic               frac_we;
  logic               count_we;
  logic               time_we;

  // A zero circumference leaves the wheel state untouched.
  assign begin_item = cmd.start && (cmd.circ != '0);
  assign modulus    = WFRAC_W'(circ_r) * WFRAC_W'(WHEEL_MOD_FACTOR);
  assign prod1      = mul_prod[WPROD1_W-1:0];
  assign total      = WTOT_W'(prod1) + (WTOT_W'(prod1) << 2) + WTOT_W'(frac_r);
  assign delta      = div_q[WDELTA_W-1:0];
  assign advance    = (delta != '0) && (speed_r != '0);
  assign prod2      = mul_prod[WDELTA_W-1:0];
  assign nine       = WNINE_W'(prod2) + (WNINE_W'(prod2) << 3);
  assign num        = mode_r ? WNUM_W'({nine, {SCALE_PWR_SH{1'b0}}})
                             : WNUM_W'({nine, {SCALE_SC_SH{1'b0}}});
  assign den        = WDEN_W'(speed_r) * WDEN_W'(WHEEL_TIME_DEN);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      W_IDLE: if (begin_item) state_nxt = W_MUL1;
      W_MUL1: if (mul_done) state_nxt = W_DIV1;
      W_DIV1: begin
        if (div_done) state_nxt = advance ? W_MUL2 : W_IDLE;
      end
      W_MUL2: if (mul_done) state_nxt = W_DIV2;
      W_DIV2: if (div_done) state_nxt = W_IDLE;
      default: state_nxt = W_IDLE;
    endcase
  end

  always_comb begin
    mul_start    = 1'b0;
    mul_a        = WM_AW'(cmd.ms);
    mul_b        = WM_BW'(cmd.speed);
    mul_len      = WM_LW'(SPEED_W);
    div_start    = 1'b0;
    div_dividend = {total, {(WD_NW-WTOT_W){1'b0}}};
    div_divisor  = WD_DW'(modulus);
    div_len      = WD_LW'(WTOT_W);
    frac_we      = 1'b0;
    count_we     = 1'b0;
    time_we      = 1'b0;
    case (state_r)
      W_IDLE: begin
        mul_start = begin_item;
      end
      W_MUL1: begin
        div_start = mul_done;
      end
      W_DIV1: begin
        frac_we   = div_done;
        count_we  = div_done && advance;
        mul_start = div_done && advance;
        mul_a     = delta;
        mul_b     = circ_r;
        mul_len   = WM_LW'(CIRC_W);
      end
      W_MUL2: begin
        div_start    = mul_done;
        div_dividend = num;
        div_divisor  = den;
        div_len      = WD_LW'(WNUM_W);
      end
      W_DIV2: begin
        time_we = div_done;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= W_IDLE;
      frac_r  <= '0;
      count_r <= '0;
      time_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (frac_we) frac_r <= div_rem[WFRAC_W-1:0];
      if (count_we) count_r <= count_r + WREV_W'(delta);
      if (time_we) time_r <= time_r + div_q[TIME_W-1:0];
    end
  end

  // Hold the item's speed and the configuration for the whole computation.
  always_ff @(posedge clk) begin
    if (begin_item && state_r == W_IDLE) begin
      speed_r <= cmd.speed;
      circ_r  <= cmd.circ;
      mode_r  <= cmd.mode;
    end
  end

  cres_smul #(.AW(WM_AW), .BW(WM_BW), .LW(WM_LW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .len   (mul_len),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  cres_sdiv #(.NW(WD_NW), .DW(WD_DW), .LW(WD_LW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .len       (div_len),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  assign busy       = (state_r != W_IDLE);
  assign revs       = count_r;
  assign event_time = time_r;

endmodule

`default_nettype wire

// File: rtl/core/cres_crank.sv
// ----------------------------------------------------------------------------
// cres_crank
// Crank lane: serial cadence integration, revolution count, event time.
// ----------------------------------------------------------------------------
`default_nettype none

module cres_crank (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cres_pkg::cres_cmd_t         cmd,
  output logic                        busy,
  output logic [cres_pkg::CREV_W-1:0] revs,
  output logic [cres_pkg::TIME_W-1:0] event_time
);
  import cres_pkg::*;

  crank_state_t state_r, state_nxt;

  logic [CAD_W-1:0]   cadence_r;
  logic [CFRAC_W-1:0] frac_r;
  logic [CREV_W-1:0]  count_r;
  logic [TIME_W-1:0]  time_r;

  logic               mul_start;
  logic               mul_done;
  logic [CM_AW+CM_BW-1:0] mul_prod;

  logic               div_start;
  logic [CD_NW-1:0]   div_dividend;
  logic [CD_DW-1:0]   div_divisor;
  logic [CD_LW-1:0]   div_len;
  logic               div_done;
  logic [CD_NW-1:0]   div_q;
  logic [CD_DW-1:0]   div_rem;

  logic [CTOT_W-1:0]   total;
  logic [CDELTA_W-1:0] delta;
  logic                advance;
  logic [CNUM_W-1:0]   num;
  logic                frac_we;
  logic                count_we;
  logic                time_we;

  assign total   = CTOT_W'(mul_prod[CPROD_W-1:0]) + CTOT_W'(frac_r);
  assign delta   = div_q[CDELTA_W-1:0];
  assign advance = (delta != '0) && (cadence_r != '0);
  // delta * 61440 as two shifts
  assign num     = (CNUM_W'(delta) << CTICK_HI_SH) - (CNUM_W'(delta) << CTICK_LO_SH);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      C_IDLE: if (cmd.start) state_nxt = C_MUL;
      C_MUL:  if (mul_done) state_nxt = C_DIV1;
      C_DIV1: begin
        if (div_done) state_nxt = advance ? C_DIV2 : C_IDLE;
      end
      C_DIV2: if (div_done) state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  always_comb begin
    mul_start    = 1'b0;
    div_start    = 1'b0;
    div_dividend = total;
    div_divisor  = CD_DW'(CRANK_MOD);
    div_len      = CD_LW'(CTOT_W);
    frac_we      = 1'b0;
    count_we     = 1'b0;
    time_we      = 1'b0;
    case (state_r)
      C_IDLE: begin
        mul_start = cmd.start;
      end
      C_MUL: begin
        div_start = mul_done;
      end
      C_DIV1: begin
        frac_we      = div_done;
        count_we     = div_done && advance;
        div_start    = div_done && advance;
        div_dividend = CD_NW'(num);
        div_divisor  = CD_DW'(cadence_r);
        div_len      = CD_LW'(CNUM_W);
      end
      C_DIV2: begin
        time_we = div_done;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      frac_r  <= '0;
      count_r <= '0;
      time_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (frac_we) frac_r <= div_rem;
      if (count_we) count_r <= count_r + CREV_W'(delta);
      if (time_we) time_r <= time_r + div_q[TIME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start && state_r == C_IDLE) begin
      cadence_r <= cmd.cadence;
    end
  end

  cres_smul #(.AW(CM_AW), .BW(CM_BW), .LW(CM_LW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (cmd.ms),
    .b     (cmd.cadence),
    .len   (CM_LW'(CAD_W)),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  cres_sdiv #(.NW(CD_NW), .DW(CD_DW), .LW(CD_LW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .len       (div_len),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  assign busy       = (state_r != C_IDLE);
  assign revs       = count_r;
  assign event_time = time_r;

endmodule

`default_nettype wire
